### rtl/gmsob_pkg.sv
// Shared types, constants and arithmetic helpers of the glyph mask blend core.
package gmsob_pkg;

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [2:0] REG_GLYPH_COLOR  = 3'd0;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd1;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd2;
    localparam logic [2:0] REG_GLYPH_LEFT   = 3'd3;
    localparam logic [2:0] REG_GLYPH_TOP    = 3'd4;
    localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd5;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd6;

    localparam int unsigned ADDR_W = 5;

    localparam logic [7:0] FULL_SCALE = 8'hFF;

    // Request queue between the classifying front and the blending back.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    typedef struct packed {
        logic       pass;
        logic [7:0] eff;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
    } blend_req_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } fifo_ctrl_t;

    // Floored division by 255, exact for every x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

### rtl/gmsob_regs.sv
// Configuration register file behind the APB-style port.
module gmsob_regs #(
    parameter int unsigned COORD_BITS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmsob_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [31:0]                   glyph_color,
    output logic [COORD_BITS-1:0]         frame_width,
    output logic [COORD_BITS-1:0]         frame_height,
    output logic [COORD_BITS-1:0]         glyph_left,
    output logic [COORD_BITS-1:0]         glyph_top,
    output logic [COORD_BITS-1:0]         glyph_width,
    output logic [COORD_BITS-1:0]         glyph_height
);

    logic [31:0]           glyph_color_reg;
    logic [COORD_BITS-1:0] frame_width_reg;
    logic [COORD_BITS-1:0] frame_height_reg;
    logic [COORD_BITS-1:0] glyph_left_reg;
    logic [COORD_BITS-1:0] glyph_top_reg;
    logic [COORD_BITS-1:0] glyph_width_reg;
    logic [COORD_BITS-1:0] glyph_height_reg;

    logic       wr_en;
    logic [2:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign index  = paddr[gmsob_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_color_reg  <= '0;
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
            glyph_left_reg   <= '0;
            glyph_top_reg    <= '0;
            glyph_width_reg  <= '0;
            glyph_height_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (index)
                gmsob_pkg::REG_GLYPH_COLOR:  glyph_color_reg  <= pwdata;
                gmsob_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[COORD_BITS-1:0];
                gmsob_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[COORD_BITS-1:0];
                gmsob_pkg::REG_GLYPH_LEFT:   glyph_left_reg   <= pwdata[COORD_BITS-1:0];
                gmsob_pkg::REG_GLYPH_TOP:    glyph_top_reg    <= pwdata[COORD_BITS-1:0];
                gmsob_pkg::REG_GLYPH_WIDTH:  glyph_width_reg  <= pwdata[COORD_BITS-1:0];
                gmsob_pkg::REG_GLYPH_HEIGHT: glyph_height_reg <= pwdata[COORD_BITS-1:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            gmsob_pkg::REG_GLYPH_COLOR:  prdata = glyph_color_reg;
            gmsob_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            gmsob_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            gmsob_pkg::REG_GLYPH_LEFT:   prdata = 32'(glyph_left_reg);
            gmsob_pkg::REG_GLYPH_TOP:    prdata = 32'(glyph_top_reg);
            gmsob_pkg::REG_GLYPH_WIDTH:  prdata = 32'(glyph_width_reg);
            gmsob_pkg::REG_GLYPH_HEIGHT: prdata = 32'(glyph_height_reg);
            default:                     prdata = '0;
        endcase
    end

    assign glyph_color  = glyph_color_reg;
    assign frame_width  = frame_width_reg;
    assign frame_height = frame_height_reg;
    assign glyph_left   = glyph_left_reg;
    assign glyph_top    = glyph_top_reg;
    assign glyph_width  = glyph_width_reg;
    assign glyph_height = glyph_height_reg;

endmodule

### rtl/gmsob_front.sv
// Front end: accepts pixels, clips them and forms the effective alpha.
module gmsob_front #(
    parameter int unsigned COORD_BITS = 14
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_BITS-1:0]       pos_x,
    input  logic [COORD_BITS-1:0]       pos_y,
    input  logic [7:0]                  mask_alpha,
    input  logic [7:0]                  dst_red,
    input  logic [7:0]                  dst_green,
    input  logic [7:0]                  dst_blue,
    input  logic [7:0]                  dst_alpha,
    input  logic [7:0]                  color_transp,
    input  logic [COORD_BITS-1:0]       frame_width,
    input  logic [COORD_BITS-1:0]       frame_height,
    input  logic [COORD_BITS-1:0]       glyph_left,
    input  logic [COORD_BITS-1:0]       glyph_top,
    input  logic [COORD_BITS-1:0]       glyph_width,
    input  logic [COORD_BITS-1:0]       glyph_height,
    output logic                        req_valid,
    input  logic                        req_ready,
    output gmsob_pkg::blend_req_t       req
);

    localparam int unsigned EW = COORD_BITS + 2;

    // Stage A: operands registered with the coverage product.
    logic                  a_valid_reg;
    logic [COORD_BITS-1:0] a_x_reg;
    logic [COORD_BITS-1:0] a_y_reg;
    logic [15:0]           a_prod_reg;
    logic [7:0]            a_red_reg;
    logic [7:0]            a_green_reg;
    logic [7:0]            a_blue_reg;
    logic [7:0]            a_alpha_reg;

    // Stage B: classified request.
    logic                  b_valid_reg;
    gmsob_pkg::blend_req_t b_req_reg;
    gmsob_pkg::blend_req_t b_req_next;

    logic a_ready;
    logic b_ready;
    logic hit_x;
    logic hit_y;

    assign b_ready  = !b_valid_reg || req_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // The base alpha of the glyph is 255 minus its transparency byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_x_reg     <= pos_x;
            a_y_reg     <= pos_y;
            a_prod_reg  <= (gmsob_pkg::FULL_SCALE - color_transp) * mask_alpha;
            a_red_reg   <= dst_red;
            a_green_reg <= dst_green;
            a_blue_reg  <= dst_blue;
            a_alpha_reg <= dst_alpha;
        end
    end

    function automatic logic in_span(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] origin,
        input logic [COORD_BITS-1:0] size,
        input logic [COORD_BITS-1:0] limit
    );
        logic signed [EW-1:0] p_s;
        logic signed [EW-1:0] o_s;
        logic signed [EW-1:0] lo_s;
        logic signed [EW-1:0] hi_s;
        logic signed [EW-1:0] lim_s;
        p_s   = $signed({{2{p[COORD_BITS-1]}}, p});
        o_s   = $signed({{2{origin[COORD_BITS-1]}}, origin});
        lim_s = $signed({2'b00, limit});
        lo_s  = origin[COORD_BITS-1] ? '0 : o_s;
        hi_s  = o_s + $signed({2'b00, size});
        if (hi_s > lim_s)
        begin
            hi_s = lim_s;
        end
        return (p_s >= lo_s) && (p_s < hi_s);
    endfunction

    assign hit_x = in_span(a_x_reg, glyph_left, glyph_width, frame_width);
    assign hit_y = in_span(a_y_reg, glyph_top, glyph_height, frame_height);

    always_comb
    begin
        b_req_next.eff       = gmsob_pkg::div255(a_prod_reg);
        b_req_next.pass      = !(hit_x && hit_y) || (b_req_next.eff == 8'd0);
        b_req_next.dst_red   = a_red_reg;
        b_req_next.dst_green = a_green_reg;
        b_req_next.dst_blue  = a_blue_reg;
        b_req_next.dst_alpha = a_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_req_reg <= b_req_next;
        end
    end

    assign req_valid = b_valid_reg;
    assign req       = b_req_reg;

endmodule

### rtl/gmsob_fifo.sv
// Short request queue between the front and back ends.
module gmsob_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  gmsob_pkg::blend_req_t wr_data,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output gmsob_pkg::blend_req_t rd_data
);

    gmsob_pkg::blend_req_t mem [gmsob_pkg::FIFO_DEPTH];

    logic [gmsob_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [gmsob_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [gmsob_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [gmsob_pkg::FIFO_CNT_W-1:0] count_next;
    gmsob_pkg::fifo_ctrl_t            ctrl;

    assign ctrl.full  = (count_reg == gmsob_pkg::FIFO_CNT_W'(gmsob_pkg::FIFO_DEPTH));
    assign ctrl.empty = (count_reg == '0);
    assign ctrl.push  = wr_valid && !ctrl.full;
    assign ctrl.pop   = rd_ready && !ctrl.empty;

    assign wr_ready = !ctrl.full;
    assign rd_valid = !ctrl.empty;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (ctrl.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= gmsob_pkg::FIFO_CNT_W'(gmsob_pkg::FIFO_DEPTH))
        else $error("request queue count beyond its depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push && !ctrl.pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("request queue count did not follow a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == gmsob_pkg::FIFO_CNT_W'(gmsob_pkg::FIFO_DEPTH))
        |-> wr_ptr_reg == rd_ptr_reg)
        else $error("request queue pointers disagree with its count");
`endif

endmodule

### rtl/gmsob_back.sv
// Back end: blends each request and holds the result for the output stream.
module gmsob_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  gmsob_pkg::blend_req_t req,
    input  logic [31:0]           glyph_color,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_red,
    output logic [7:0]            out_green,
    output logic [7:0]            out_blue,
    output logic [7:0]            out_alpha,
    output logic                  modified
);

    logic [7:0] inv_eff;

    // Stage C: weighted sums of source and destination.
    logic        c_valid_reg;
    logic        c_pass_reg;
    logic [7:0]  c_eff_reg;
    logic [15:0] c_sum_r_reg;
    logic [15:0] c_sum_g_reg;
    logic [15:0] c_sum_b_reg;
    logic [15:0] c_sum_a_reg;
    logic [7:0]  c_red_reg;
    logic [7:0]  c_green_reg;
    logic [7:0]  c_blue_reg;
    logic [7:0]  c_alpha_reg;

    // Stage D: output register.
    logic        d_valid_reg;
    logic [7:0]  d_red_reg;
    logic [7:0]  d_green_reg;
    logic [7:0]  d_blue_reg;
    logic [7:0]  d_alpha_reg;
    logic        d_mod_reg;

    logic [8:0]  alpha_sum;
    logic [7:0]  alpha_sat;
    logic        c_ready;
    logic        d_ready;

    assign d_ready   = !d_valid_reg || out_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign req_ready = c_ready;
    assign inv_eff   = gmsob_pkg::FULL_SCALE - req.eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_ready)
            begin
                c_valid_reg <= req_valid;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && req_valid)
        begin
            c_pass_reg  <= req.pass;
            c_eff_reg   <= req.eff;
            c_sum_r_reg <= glyph_color[31:24] * req.eff + req.dst_red * inv_eff;
            c_sum_g_reg <= glyph_color[23:16] * req.eff + req.dst_green * inv_eff;
            c_sum_b_reg <= glyph_color[15:8] * req.eff + req.dst_blue * inv_eff;
            c_sum_a_reg <= req.dst_alpha * inv_eff;
            c_red_reg   <= req.dst_red;
            c_green_reg <= req.dst_green;
            c_blue_reg  <= req.dst_blue;
            c_alpha_reg <= req.dst_alpha;
        end
    end

    // The combined alpha cannot exceed full scale, but it is clamped all the same.
    assign alpha_sum = {1'b0, c_eff_reg} + {1'b0, gmsob_pkg::div255(c_sum_a_reg)};
    assign alpha_sat = alpha_sum[8] ? gmsob_pkg::FULL_SCALE : alpha_sum[7:0];

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            if (c_pass_reg)
            begin
                d_red_reg   <= c_red_reg;
                d_green_reg <= c_green_reg;
                d_blue_reg  <= c_blue_reg;
                d_alpha_reg <= c_alpha_reg;
            end
            else
            begin
                d_red_reg   <= gmsob_pkg::div255(c_sum_r_reg);
                d_green_reg <= gmsob_pkg::div255(c_sum_g_reg);
                d_blue_reg  <= gmsob_pkg::div255(c_sum_b_reg);
                d_alpha_reg <= alpha_sat;
            end
            d_mod_reg <= !c_pass_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_red   = d_red_reg;
    assign out_green = d_green_reg;
    assign out_blue  = d_blue_reg;
    assign out_alpha = d_alpha_reg;
    assign modified  = d_mod_reg;

endmodule

### rtl/glyph_mask_src_over_blend_core.sv
// Top level of the glyph mask source-over blend core.
//
// Blends a uniformly coloured glyph mask over an RGBA8 pixel stream, one pixel per
// clock sustained while m_tready does not hold it back. Each accepted request passes
// two front stages (coverage product, then clipping against the glyph rectangle and
// frame and the effective alpha), a four-entry request queue, and two back stages
// (per-channel weighted sums, then the divide by 255 into the output register). The
// 8x8 multipliers of the product and sum stages are not shared, one set per pixel.
// The user must write the registers over the APB-style port only while the stream
// is idle; the block itself does not enforce it. glyph_color sits at 0x00, then
// frame width and height, glyph left, top, width and height every four bytes.
module glyph_mask_src_over_blend_core #(
    parameter int unsigned COORD_BITS = 14
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [gmsob_pkg::ADDR_W-1:0]           paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // pos_x, pos_y, mask_alpha, dst_red, dst_green, dst_blue, dst_alpha, zero fill
    input  logic [((2*COORD_BITS+47)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]                            m_tdata,
    // modified
    output logic [0:0]                             m_tuser
);

    localparam int unsigned XB = 0;
    localparam int unsigned YB = COORD_BITS;
    localparam int unsigned MB = 2 * COORD_BITS;

    logic [31:0]           glyph_color;
    logic [COORD_BITS-1:0] frame_width;
    logic [COORD_BITS-1:0] frame_height;
    logic [COORD_BITS-1:0] glyph_left;
    logic [COORD_BITS-1:0] glyph_top;
    logic [COORD_BITS-1:0] glyph_width;
    logic [COORD_BITS-1:0] glyph_height;

    logic                  f_valid;
    logic                  f_ready;
    gmsob_pkg::blend_req_t f_req;
    logic                  q_valid;
    logic                  q_ready;
    gmsob_pkg::blend_req_t q_req;

    gmsob_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .glyph_color  (glyph_color),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .glyph_left   (glyph_left),
        .glyph_top    (glyph_top),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height)
    );

    gmsob_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .pos_x        (s_tdata[XB +: COORD_BITS]),
        .pos_y        (s_tdata[YB +: COORD_BITS]),
        .mask_alpha   (s_tdata[MB +: 8]),
        .dst_red      (s_tdata[MB + 8 +: 8]),
        .dst_green    (s_tdata[MB + 16 +: 8]),
        .dst_blue     (s_tdata[MB + 24 +: 8]),
        .dst_alpha    (s_tdata[MB + 32 +: 8]),
        .color_transp (glyph_color[7:0]),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .glyph_left   (glyph_left),
        .glyph_top    (glyph_top),
        .glyph_width  (glyph_width),
        .glyph_height (glyph_height),
        .req_valid    (f_valid),
        .req_ready    (f_ready),
        .req          (f_req)
    );

    gmsob_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_req),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_req)
    );

    gmsob_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (q_valid),
        .req_ready   (q_ready),
        .req         (q_req),
        .glyph_color (glyph_color),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_red     (m_tdata[7:0]),
        .out_green   (m_tdata[15:8]),
        .out_blue    (m_tdata[23:16]),
        .out_alpha   (m_tdata[31:24]),
        .modified    (m_tuser[0])
    );

endmodule
